FILE: design/jhbc_pkg.sv
// Package: Huffman code tables and shared types for the JPEG block coder.
`default_nettype none
package jhbc_pkg;

  // One coded symbol handed from the symbol stage to the output stage.
  typedef struct packed {
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [10:0] extra_bits;
    logic [3:0]  extra_length;
  } sym_t;

  // DC luma: sizes 0..11.
  function automatic logic [20:0] dc_luma(input logic [3:0] s);
    logic [20:0] r;
    begin
      case (s)
        4'd0:  r = {5'd2, 16'h0000};
        4'd1:  r = {5'd3, 16'h0002};
        4'd2:  r = {5'd3, 16'h0003};
        4'd3:  r = {5'd3, 16'h0004};
        4'd4:  r = {5'd3, 16'h0005};
        4'd5:  r = {5'd3, 16'h0006};
        4'd6:  r = {5'd4, 16'h000e};
        4'd7:  r = {5'd5, 16'h001e};
        4'd8:  r = {5'd6, 16'h003e};
        4'd9:  r = {5'd7, 16'h007e};
        4'd10: r = {5'd8, 16'h00fe};
        4'd11: r = {5'd9, 16'h01fe};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // DC chroma: sizes 0..11.
  function automatic logic [20:0] dc_chroma(input logic [3:0] s);
    logic [20:0] r;
    begin
      case (s)
        4'd0:  r = {5'd2, 16'h0000};
        4'd1:  r = {5'd2, 16'h0001};
        4'd2:  r = {5'd2, 16'h0002};
        4'd3:  r = {5'd3, 16'h0006};
        4'd4:  r = {5'd4, 16'h000e};
        4'd5:  r = {5'd5, 16'h001e};
        4'd6:  r = {5'd6, 16'h003e};
        4'd7:  r = {5'd7, 16'h007e};
        4'd8:  r = {5'd8, 16'h00fe};
        4'd9:  r = {5'd9, 16'h01fe};
        4'd10: r = {5'd10, 16'h03fe};
        4'd11: r = {5'd11, 16'h07fe};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  localparam logic [7:0] AcLumaVals [162] = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,
    8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,8'h42,8'hb1,8'hc1,
    8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,
    8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
    8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,
    8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
    8'hd9,8'hda,8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  localparam logic [7:0] AcChromaVals [162] = '{
    8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,8'h51,8'h07,
    8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,8'hb1,8'hc1,8'h09,
    8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,8'h24,8'h34,8'he1,8'h25,
    8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h35,8'h36,8'h37,8'h38,
    8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,
    8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,
    8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,
    8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,
    8'hd7,8'hd8,8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,
    8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};

  localparam logic [7:0] AcLumaBits [16] = '{
    8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,8'd0,8'd0,8'd1,8'h7d};
  localparam logic [7:0] AcChromaBits [16] = '{
    8'd0,8'd2,8'd1,8'd2,8'd4,8'd4,8'd3,8'd4,8'd7,8'd5,8'd4,8'd4,8'd0,8'd1,8'd2,8'h77};

  // Build a canonical codebook indexed by symbol: {length, code}; elaboration only.
  typedef logic [20:0] book_t [256];

  function automatic book_t build_book(input logic chroma);
    book_t b;
    int code;
    int k;
    int n;
    logic [7:0] v;
    begin
      for (int i = 0; i < 256; i++) b[i] = '0;
      code = 0;
      k = 0;
      for (int l = 1; l <= 16; l++) begin
        n = chroma ? int'(AcChromaBits[l-1]) : int'(AcLumaBits[l-1]);
        for (int i = 0; i < n; i++) begin
          v = chroma ? AcChromaVals[k] : AcLumaVals[k];
          b[v] = {5'(l), 16'(code)};
          code++;
          k++;
        end
        code = code << 1;
      end
      return b;
    end
  endfunction

  localparam book_t AcLumaBook   = build_book(1'b0);
  localparam book_t AcChromaBook = build_book(1'b1);

  localparam logic [7:0] SymEob = 8'h00;
  localparam logic [7:0] SymZrl = 8'hf0;
  localparam logic [5:0] RunZrl = 6'd16;
  localparam logic [5:0] PosLast = 6'd63;
  localparam logic [5:0] RunMax = 6'd63;

  // Size category of a magnitude up to 11 bits.
  function automatic logic [3:0] size_of(input logic [10:0] m);
    logic [3:0] s;
    begin
      s = '0;
      for (int i = 0; i < 11; i++) if (m[i]) s = 4'(i + 1);
      return s;
    end
  endfunction

  // Low s bits of v, one's complement when negative (v is 12-bit signed).
  function automatic logic [10:0] extra_of(input logic [11:0] v, input logic [3:0] s);
    logic [11:0] r;
    logic [11:0] mask;
    begin
      mask = (12'd1 << s) - 12'd1;
      r = v[11] ? (v - 12'd1) : v;
      return 11'(r & mask);
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/jhbc_symbol.sv
// Symbol stage: turns a registered coefficient into up to four Huffman symbols.
`default_nettype none
module jhbc_symbol #(
  parameter int COMPONENTS = 3
) (
  input  wire logic [10:0] coefficient_i,
  input  wire logic [1:0]  component_i,
  input  wire logic [5:0]  position_i,
  input  wire logic [2:0]  dc_sel_i,
  input  wire logic [2:0]  ac_sel_i,
  input  wire logic [10:0] pred_i,
  input  wire logic [5:0]  run_i,
  output logic             valid_comp_o,
  output logic [2:0]       zrl_count_o,
  output logic             has_main_o,
  output jhbc_pkg::sym_t   zrl_sym_o,
  output jhbc_pkg::sym_t   main_sym_o,
  output logic [5:0]       run_next_o
);
  logic        dc_chroma_sel;
  logic        ac_chroma_sel;
  logic [11:0] diff;
  logic [11:0] mag;
  logic [3:0]  sz;
  logic [11:0] coef_sat;
  logic [7:0]  ac_sym;
  logic [20:0] dc_entry;
  logic [20:0] ac_entry;
  logic [20:0] zrl_entry;
  logic [5:0]  run_rem;

  // Pick tables; components without a select bit use luma
  always_comb begin
    dc_chroma_sel = (component_i < 2'd3) ? dc_sel_i[component_i] : 1'b0;
    ac_chroma_sel = (component_i < 2'd3) ? ac_sel_i[component_i] : 1'b0;
  end

  assign valid_comp_o = (32'(component_i) < COMPONENTS);

  // Compute value, size and symbol
  always_comb begin
    diff = {coefficient_i[10], coefficient_i} - {pred_i[10], pred_i};
    coef_sat = (coefficient_i == 11'h400) ? 12'hc01 : {coefficient_i[10], coefficient_i};
    run_rem = {2'b00, run_i[3:0]};
    zrl_count_o = 3'(run_i[5:4]);
    has_main_o = 1'b1;
    run_next_o = 6'd0;
    if (position_i == 6'd0) begin
      mag = diff[11] ? (12'd0 - diff) : diff;
    end else begin
      mag = coef_sat[11] ? (12'd0 - coef_sat) : coef_sat;
    end
    sz = jhbc_pkg::size_of(mag[10:0]);
    ac_sym = {run_rem[3:0], sz};
    main_sym_o.extra_bits = jhbc_pkg::extra_of(position_i == 6'd0 ? diff : coef_sat, sz);
    main_sym_o.extra_length = sz;
    if (position_i != 6'd0) begin
      if (coefficient_i == 11'd0) begin
        zrl_count_o = 3'd0;
        main_sym_o.extra_bits = '0;
        main_sym_o.extra_length = '0;
        ac_sym = jhbc_pkg::SymEob;
        if (position_i != jhbc_pkg::PosLast) begin
          has_main_o = 1'b0;
          run_next_o = (run_i == jhbc_pkg::RunMax) ? run_i : run_i + 6'd1;
        end
      end
    end
    dc_entry  = dc_chroma_sel ? jhbc_pkg::dc_chroma(sz) : jhbc_pkg::dc_luma(sz);
    ac_entry  = ac_chroma_sel ? jhbc_pkg::AcChromaBook[ac_sym] : jhbc_pkg::AcLumaBook[ac_sym];
    zrl_entry = ac_chroma_sel ? jhbc_pkg::AcChromaBook[jhbc_pkg::SymZrl]
                              : jhbc_pkg::AcLumaBook[jhbc_pkg::SymZrl];
    if (position_i == 6'd0) begin
      zrl_count_o = 3'd0;
      main_sym_o.code_bits = dc_entry[15:0];
      main_sym_o.code_length = dc_entry[20:16];
    end else begin
      main_sym_o.code_bits = ac_entry[15:0];
      main_sym_o.code_length = ac_entry[20:16];
    end
    zrl_sym_o.code_bits = zrl_entry[15:0];
    zrl_sym_o.code_length = zrl_entry[20:16];
    zrl_sym_o.extra_bits = '0;
    zrl_sym_o.extra_length = '0;
  end
endmodule
`default_nettype wire

FILE: design/jpeg_huffman_block_coder_core.sv
// Top level of the JPEG baseline Huffman block coder.
// Accepts one zigzag-ordered quantized coefficient per beat and emits Huffman
// symbol beats (codeword plus extra magnitude bits, final_result on the last
// beat of each coefficient). A coefficient is taken into an input register and
// its symbols leave through one output register; one beat in per cycle is
// sustained unless the output stalls. A nonzero AC coefficient preceded by 16
// or more zeros first sends one ZRL beat per 16 zeros (up to three), holding
// input meanwhile; a zero AC coefficient emits nothing unless at position 63.
`default_nettype none
module jpeg_huffman_block_coder_core #(
  parameter int COMPONENTS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [10:0] coefficient_i,
  input  wire logic [1:0]  component_i,
  input  wire logic [5:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      code_bits_o,
  output logic [4:0]       code_length_o,
  output logic [10:0]      extra_bits_o,
  output logic [3:0]       extra_length_o,
  output logic             final_result_o
);
  localparam int CompW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam logic CfgDc = 1'b0;
  localparam logic CfgAc = 1'b1;

  logic [2:0] dc_sel_q, ac_sel_q;
  logic [10:0] pred_q [COMPONENTS];
  logic [5:0] run_q;

  // input register
  logic        hold_q;
  logic [10:0] coef_q;
  logic [1:0]  comp_q;
  logic [5:0]  pos_q;
  logic [2:0]  zrl_done_q;

  // output register
  logic           ov_q;
  jhbc_pkg::sym_t osym_q;
  logic           ofin_q;

  logic           valid_comp, has_main;
  logic [2:0]     zrl_count;
  jhbc_pkg::sym_t zrl_sym, main_sym;
  logic [5:0]     run_next;
  logic [10:0]    pred_sel;
  logic           out_free, emit_zrl, emit_main, item_done, take;

  always_comb begin
    pred_sel = '0;
    for (int c = 0; c < COMPONENTS; c++) if (comp_q == 2'(c)) pred_sel = pred_q[c];
  end

  jhbc_symbol #(.COMPONENTS(COMPONENTS)) u_sym (
    .coefficient_i(coef_q), .component_i(comp_q), .position_i(pos_q),
    .dc_sel_i(dc_sel_q), .ac_sel_i(ac_sel_q), .pred_i(pred_sel), .run_i(run_q),
    .valid_comp_o(valid_comp), .zrl_count_o(zrl_count), .has_main_o(has_main),
    .zrl_sym_o(zrl_sym), .main_sym_o(main_sym), .run_next_o(run_next)
  );

  // Sequence ZRL beats then the main beat
  always_comb begin
    out_free  = !ov_q || out_ready_i;
    emit_zrl  = hold_q && valid_comp && (zrl_done_q < zrl_count) && out_free;
    emit_main = hold_q && valid_comp && (zrl_done_q == zrl_count) && has_main && out_free;
    item_done = hold_q && (!valid_comp || emit_main ||
                           (zrl_done_q == zrl_count && !has_main));
    in_ready_o = !hold_q || item_done;
    take = in_valid_i && in_ready_o;
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_sel_q <= 3'd6;
      ac_sel_q <= 3'd6;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDc: dc_sel_q <= cfg_data_i;
        CfgAc: ac_sel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the input side and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      run_q <= '0;
      zrl_done_q <= '0;
      for (int c = 0; c < COMPONENTS; c++) pred_q[c] <= '0;
    end else begin
      if (emit_zrl) zrl_done_q <= zrl_done_q + 3'd1;
      if (item_done) begin
        zrl_done_q <= '0;
        if (valid_comp) begin
          run_q <= run_next;
          if (pos_q == 6'd0) pred_q[comp_q[CompW-1:0]] <= coef_q;
        end
      end
      if (take) hold_q <= 1'b1;
      else if (item_done) hold_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      coef_q <= coefficient_i;
      comp_q <= component_i;
      pos_q  <= position_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (emit_zrl || emit_main) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit_zrl) begin
      osym_q <= zrl_sym;
      ofin_q <= 1'b0;
    end else if (emit_main) begin
      osym_q <= main_sym;
      ofin_q <= 1'b1;
    end
  end

  assign out_valid_o    = ov_q;
  assign code_bits_o    = osym_q.code_bits;
  assign code_length_o  = osym_q.code_length;
  assign extra_bits_o   = osym_q.extra_bits;
  assign extra_length_o = osym_q.extra_length;
  assign final_result_o = ofin_q;

  a_zrl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zrl_done_q <= 3'd3) else $error("ZRL count overran");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |-> !(emit_zrl || emit_main)) else $error("output overwritten");
  a_zrl_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(emit_zrl) |-> (ov_q && !ofin_q)) else $error("ZRL beat marked final");
  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (zrl_done_q == 3'd0)) else $error("ZRL counter not cleared");
endmodule
`default_nettype wire

FILE: verif/jpeg_huffman_block_coder_checker.sv
// Checker for the JPEG Huffman block coder: predicts symbol beats and compares them.
module jpeg_huffman_block_coder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [10:0] coefficient_i,
  input  logic [1:0]  component_i,
  input  logic [5:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] code_bits_i,
  input  logic [4:0]  code_length_i,
  input  logic [10:0] extra_bits_i,
  input  logic [3:0]  extra_length_i,
  input  logic        final_result_i,
  output int          errors_o,
  output int          pending_o,
  output int          beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumComp = 3;
  localparam logic CfgDc = 1'b0;
  localparam logic CfgAc = 1'b1;
  localparam logic [7:0] SymbolEob = 8'h00;
  localparam logic [7:0] SymbolZrl = 8'hf0;
  localparam logic [5:0] LastPos = 6'd63;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  clen;
    logic [10:0] extra;
    logic [3:0]  elen;
    logic        last;
  } symbol_beat_t;

  // Canonical codebooks: 0 DC luma, 1 DC chroma, 2 AC luma, 3 AC chroma.
  logic [15:0] book_code [4][256];
  logic [4:0]  book_len  [4][256];

  logic [2:0]  dc_sel, ac_sel;
  logic signed [10:0] dc_pred [NumComp];
  logic [5:0]  zero_count;
  symbol_beat_t expected_symbols [$];
  int errors;

  assign errors_o = errors;
  assign pending_o = expected_symbols.size();

  // Fill one codebook from its counts-per-length and symbol list.
  task automatic fill_book(input int t, input int counts [16], input int syms [$]);
    int code;
    int k;
    code = 0;
    k = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int i = 0; i < counts[l-1]; i++) begin
        book_code[t][syms[k]] = 16'(code);
        book_len[t][syms[k]] = 5'(l);
        code++;
        k++;
      end
      code = code << 1;
    end
  endtask

  initial begin
    int dcl [16] = '{0,1,5,1,1,1,1,1,1,0,0,0,0,0,0,0};
    int dcc [16] = '{0,3,1,1,1,1,1,1,1,1,1,0,0,0,0,0};
    int acl [16] = '{0,2,1,3,3,2,4,3,5,5,4,4,0,0,1,125};
    int acc [16] = '{0,2,1,2,4,4,3,4,7,5,4,4,0,1,2,119};
    int dcv [$];
    int aclv [$];
    int accv [$];
    for (int t = 0; t < 4; t++)
      for (int s = 0; s < 256; s++) begin
        book_code[t][s] = '0;
        book_len[t][s] = '0;
      end
    for (int s = 0; s < 12; s++) dcv.push_back(s);
    aclv = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
      8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,
      8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,
      8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,
      8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
      8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,
      8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,
      8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,
      8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,
      8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,
      8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
      8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,
      8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    accv = '{8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
      8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,
      8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,
      8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,
      8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,
      8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,
      8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,
      8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,
      8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,
      8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,
      8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,
      8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    fill_book(0, dcl, dcv);
    fill_book(1, dcc, dcv);
    fill_book(2, acl, aclv);
    fill_book(3, acc, accv);
  end

  // Size category of a signed value.
  function automatic int category(input int v);
    int m;
    int s;
    m = (v < 0) ? -v : v;
    s = 0;
    while (m != 0) begin
      s++;
      m = m >> 1;
    end
    return s;
  endfunction

  function automatic symbol_beat_t make_beat(input int t, input int sym, input int v,
                                             input int s);
    symbol_beat_t b;
    int r;
    r = (v >= 0) ? v : v + ((1 << s) - 1);
    b.code = book_code[t][sym];
    b.clen = book_len[t][sym];
    b.extra = 11'(r & ((1 << s) - 1));
    b.elen = 4'(s);
    b.last = 1'b0;
    return b;
  endfunction

  // Work out the symbol beats one coefficient causes and update the coder state.
  task automatic encode_coefficient(input logic [10:0] raw, input logic [1:0] comp,
                                    input logic [5:0] pos);
    symbol_beat_t produced [$];
    int coef;
    int diff;
    int t;
    int s;
    coef = int'($signed(raw));
    if (comp >= NumComp) return;
    if (pos == 0) begin
      t = dc_sel[comp];
      diff = coef - int'(dc_pred[comp]);
      s = category(diff);
      produced.push_back(make_beat(t, s, diff, s));
      dc_pred[comp] = $signed(raw);
      zero_count = '0;
    end else begin
      t = 2 + ac_sel[comp];
      if (coef == 0) begin
        if (pos == LastPos) begin
          produced.push_back(make_beat(t, SymbolEob, 0, 0));
          zero_count = '0;
        end else if (zero_count < 6'd63) begin
          zero_count++;
        end
      end else begin
        if (coef < -1023) coef = -1023;
        while (zero_count >= 6'd16) begin
          produced.push_back(make_beat(t, SymbolZrl, 0, 0));
          zero_count -= 6'd16;
        end
        s = category(coef);
        produced.push_back(make_beat(t, (int'(zero_count) << 4) | s, coef, s));
        zero_count = '0;
      end
    end
    if (produced.size() > 0) produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) expected_symbols.push_back(produced[i]);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Track config, accepted coefficients and symbol beats at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    symbol_beat_t want;
    if (!rst_ni) begin
      dc_sel = 3'd6;
      ac_sel = 3'd6;
      for (int c = 0; c < NumComp; c++) dc_pred[c] = '0;
      zero_count = '0;
      expected_symbols.delete();
      errors = 0;
      beats_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgDc) dc_sel = cfg_data_i;
        else if (cfg_index_i == CfgAc) ac_sel = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        beats_o++;
        if (expected_symbols.size() == 0) begin
          report("unexpected beat code", code_bits_i, 0);
        end else begin
          want = expected_symbols.pop_front();
          if (code_bits_i !== want.code) report("code_bits", code_bits_i, want.code);
          if (code_length_i !== want.clen) report("code_length", code_length_i, want.clen);
          if (extra_bits_i !== want.extra) report("extra_bits", extra_bits_i, want.extra);
          if (extra_length_i !== want.elen) report("extra_length", extra_length_i, want.elen);
          if (final_result_i !== want.last) report("final_result", final_result_i, want.last);
        end
      end
      if (in_valid_i && in_ready_i) encode_coefficient(coefficient_i, component_i, position_i);
    end
  end

endmodule

FILE: verif/jpeg_huffman_block_coder_core_tb.sv
// Testbench top for the JPEG Huffman block coder: stimulus, stalls and verdict.
module jpeg_huffman_block_coder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CfgDc = 1'b0;
  localparam logic CfgAc = 1'b1;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [2:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [10:0] coefficient_i = '0;
  logic [1:0]  component_i = '0;
  logic [5:0]  position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_bits_o;
  logic [4:0]  code_length_o;
  logic [10:0] extra_bits_o;
  logic [3:0]  extra_length_o;
  logic        final_result_o;
  int          errors, pending, beats, cycles, coef_count;
  bit          quiet_sink;

  always #10 clk_i = ~clk_i;

  jpeg_huffman_block_coder_core u_top (.*);

  jpeg_huffman_block_coder_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .coefficient_i, .component_i, .position_i,
    .out_valid_i(out_valid_o), .out_ready_i, .code_bits_i(code_bits_o),
    .code_length_i(code_length_o), .extra_bits_i(extra_bits_o),
    .extra_length_i(extra_length_o), .final_result_i(final_result_o),
    .errors_o(errors), .pending_o(pending), .beats_o(beats)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if (quiet_sink) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Stall the symbol output at random.
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 4) begin
        out_ready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end else if (g == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Present one coefficient beat and hold it until accepted; valid drops only on a gap.
  task automatic send_coef(input int coef, input int comp, input int pos);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coefficient_i <= 11'(coef);
    component_i <= 2'(comp);
    position_i <= 6'(pos);
    do @(posedge clk_i); while (!in_ready_o);
    coef_count++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, drain outstanding beats, then let the pipeline settle before a write.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2047) - 1024;
      1: return 1023;
      2: return -1024;
      default: return $urandom_range(0, 14) - 7;
    endcase
  endfunction

  // One block with random content: mostly well formed, sometimes cut short.
  task automatic send_block(input int comp, input int len);
    int p;
    int coef;
    int step;
    send_coef(rand_coef(), comp, 0);
    p = 1;
    while (p < len) begin
      coef = ($urandom_range(0, 9) < 7) ? 0 : rand_coef();
      if (p == 63 && $urandom_range(0, 1) == 0) coef = rand_coef();
      send_coef(coef, comp, p);
      step = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 12) : 1;
      if (len == 64 && p < 63 && p + step > 63) p = 63;
      else p += step;
    end
  endtask

  initial begin
    logic [2:0] settings [4];
    settings = '{3'd0, 3'd7, 3'd6, 3'd5};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of DC, a long zero run, saturation, block end cases.
    quiet_sink = 1'b1;
    send_coef(1023, 0, 0);
    send_coef(-1024, 0, 0);
    send_coef(1023, 1, 0);
    send_coef(-1, 2, 0);
    send_coef(5, 3, 0);
    send_coef(-1024, 0, 1);
    send_coef(1023, 1, 2);
    for (int p = 3; p < 55; p++) send_coef(0, 0, p);
    send_coef(-3, 0, 55);
    send_coef(0, 0, 56);
    send_coef(0, 0, 63);
    send_coef(0, 2, 0);
    for (int p = 1; p < 60; p++) send_coef(0, 2, 10);
    send_coef(1, 2, 62);
    send_coef(-2, 2, 63);
    quiet_sink = 1'b0;

    // Random blocks across several table selections, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CfgDc, settings[ph]);
      write_reg(CfgAc, settings[(ph + 1) % 4] ^ 3'd2);
      for (int b = 0; b < 2; b++)
        send_block($urandom_range(0, 3), ($urandom_range(0, 4) == 0) ?
                   $urandom_range(2, 40) : 64);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("sent %0d coefficients over four table settings, checked %0d symbol beats",
             coef_count, beats);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
design/jhbc_pkg.sv
design/jhbc_symbol.sv
design/jpeg_huffman_block_coder_core.sv
verif/jpeg_huffman_block_coder_checker.sv
verif/jpeg_huffman_block_coder_core_tb.sv
